// ===== hw/rtl/efb_pkg.sv =====
// efb_pkg: shared types, codes and helpers for the escaped frame builder
// used by efb_front, efb_emit and escaped_frame_builder; no dependencies
package efb_pkg;

  localparam logic [7:0] EscLead   = 8'h10;
  localparam logic [7:0] EscOffset = 8'h20;

  localparam logic [7:0] StartReset  = 8'h01;
  localparam logic [7:0] PrefixReset = 8'h00;
  localparam logic [7:0] EndReset    = 8'h04;

  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_PREFIX = 2'd1,
    CFG_END    = 2'd2,
    CFG_SPARE  = 2'd3
  } efb_cfg_idx_e;

  typedef enum logic [2:0] {
    SLOT_BEGIN,
    SLOT_START,
    SLOT_PREFIX,
    SLOT_DATA,
    SLOT_CHK_HI,
    SLOT_CHK_LO,
    SLOT_END
  } efb_slot_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } efb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } efb_out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] prefix_byte;
    logic [7:0] end_byte;
  } efb_cfg_t;

  // one accepted beat, ready for the emitter
  typedef struct packed {
    logic        first;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] chk;
  } efb_job_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == 8'h01) || (b == 8'h04) || (b == 8'h10) ||
           (b == 8'h11) || (b == 8'h13);
  endfunction

endpackage

// ===== hw/rtl/efb_front.sv =====
// efb_front: input register of the escaped frame builder, keeps frame state
// and the running sum; depends on efb_pkg
module efb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efb_pkg::efb_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  efb_pkg::efb_in_t  in_data_i,
  input  logic              job_take_i,
  output logic              job_valid_o,
  output efb_pkg::efb_job_t job_o
);
  import efb_pkg::*;

  logic        in_frame_q, in_frame_d;
  logic [15:0] sum_q, sum_d;
  logic        job_valid_q, job_valid_d;
  efb_job_t    job_q, job_d;
  logic        accept;
  logic [15:0] sum_base, sum_new;

  // the held beat leaves in the cycle its last byte is loaded out
  assign in_stall_o = job_valid_q && !job_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign sum_base = in_frame_q ? sum_q : {8'h00, cfg_i.prefix_byte};
  assign sum_new  = sum_base + {8'h00, in_data_i.data_byte};

  always_comb begin
    in_frame_d  = in_frame_q;
    sum_d       = sum_q;
    job_valid_d = job_valid_q;
    job_d       = job_q;
    if (accept) begin
      job_valid_d     = 1'b1;
      job_d.first     = !in_frame_q;
      job_d.data_byte = in_data_i.data_byte;
      job_d.last_byte = in_data_i.last_byte;
      job_d.chk       = ~sum_new;
      if (in_data_i.last_byte) begin
        in_frame_d = 1'b0;
        sum_d      = 16'h0000;
      end else begin
        in_frame_d = 1'b1;
        sum_d      = sum_new;
      end
    end else if (job_take_i) begin
      job_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      sum_q       <= 16'h0000;
      job_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      sum_q       <= sum_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// ===== hw/rtl/efb_emit.sv =====
// efb_emit: walks the byte slots of one held beat and drives the output
// register, one byte per cycle while out_stall_i is low; depends on efb_pkg
module efb_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efb_pkg::efb_cfg_t cfg_i,
  input  logic              job_valid_i,
  input  efb_pkg::efb_job_t job_i,
  output logic              job_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efb_pkg::efb_out_t out_data_o
);
  import efb_pkg::*;

  efb_slot_e slot_q, slot_d, slot_cur;
  logic      esc_q, esc_d;
  logic      out_valid_q, out_valid_d;
  efb_out_t  out_q, out_d;
  logic      load;
  logic      escapable;
  logic [7:0] raw_byte;
  logic      step_done;
  efb_slot_e slot_next;

  assign load = job_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    slot_cur = slot_q;
    if (slot_q == SLOT_BEGIN) begin
      slot_cur = job_i.first ? SLOT_START : SLOT_DATA;
    end
  end

  always_comb begin
    escapable = 1'b0;
    raw_byte  = job_i.data_byte;
    slot_next = SLOT_BEGIN;
    step_done = 1'b0;
    unique case (slot_cur)
      SLOT_START: begin
        raw_byte  = cfg_i.start_byte;
        slot_next = SLOT_PREFIX;
      end
      SLOT_PREFIX: begin
        raw_byte  = cfg_i.prefix_byte;
        slot_next = SLOT_DATA;
      end
      SLOT_DATA: begin
        escapable = 1'b1;
        raw_byte  = job_i.data_byte;
        slot_next = job_i.last_byte ? SLOT_CHK_HI : SLOT_BEGIN;
        step_done = !job_i.last_byte;
      end
      SLOT_CHK_HI: begin
        escapable = 1'b1;
        raw_byte  = job_i.chk[15:8];
        slot_next = SLOT_CHK_LO;
      end
      SLOT_CHK_LO: begin
        escapable = 1'b1;
        raw_byte  = job_i.chk[7:0];
        slot_next = SLOT_END;
      end
      SLOT_END: begin
        raw_byte  = cfg_i.end_byte;
        slot_next = SLOT_BEGIN;
        step_done = 1'b1;
      end
      default: begin
        raw_byte  = job_i.data_byte;
        slot_next = SLOT_BEGIN;
      end
    endcase
  end

  always_comb begin
    slot_d      = slot_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    job_take_o  = 1'b0;
    if (load) begin
      out_valid_d     = 1'b1;
      out_d.frame_end = (slot_cur == SLOT_END);
      if (escapable && needs_escape(raw_byte) && !esc_q) begin
        // lead byte first, then the shifted code from the same slot
        out_d.out_byte = EscLead;
        out_d.run_last = 1'b0;
        esc_d          = 1'b1;
        slot_d         = slot_cur;
      end else begin
        out_d.out_byte = esc_q ? raw_byte + EscOffset : raw_byte;
        out_d.run_last = step_done;
        esc_d          = 1'b0;
        slot_d         = slot_next;
        job_take_o     = step_done;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SLOT_BEGIN;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/escaped_frame_builder.sv =====
// escaped_frame_builder: top level, holds the marker registers and joins
// the input register to the byte emitter; depends on efb_pkg, efb_front, efb_emit
//
// Each input beat is one body byte of a frame. The first beat of a frame is
// preceded by the start and prefix markers; bytes 0x01, 0x04, 0x10, 0x11 and
// 0x13 go out as 0x10 then the byte plus 0x20; the final beat is followed by
// the inverted 16-bit sum of prefix and body (high byte first, escaped) and
// the end marker, which carries frame_end. run_last marks the last output
// byte caused by a beat. The output register sends one byte per cycle while
// out_stall_i is low; a beat causes 1 or 2 output bytes as a plain body
// byte, up to 9 for a single-byte frame. The input register takes the next
// beat in the cycle the current one hands over its last byte, so beats flow
// with no gap. Register writes (0 start, 1 prefix, 2 end) are always ready
// and belong in idle time, with no beat in flight.
module escaped_frame_builder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  efb_pkg::efb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efb_pkg::efb_out_t out_data_o
);
  import efb_pkg::*;

  efb_cfg_t cfg_q, cfg_d;
  logic     job_valid;
  logic     job_take;
  efb_job_t job;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (efb_cfg_idx_e'(cfg_index_i))
        CFG_START:  cfg_d.start_byte  = cfg_data_i;
        CFG_PREFIX: cfg_d.prefix_byte = cfg_data_i;
        CFG_END:    cfg_d.end_byte    = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= StartReset;
      cfg_q.prefix_byte <= PrefixReset;
      cfg_q.end_byte    <= EndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  efb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_take_i  (job_take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  efb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
